// ===== src/abpc_pkg.sv =====
// Shared types, register codes and fixed-point helpers of the alpha blend compositor.
`default_nettype none
package abpc_pkg;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 24;
  localparam int QueueDepth    = 4;

  localparam logic [CfgIndexWidth-1:0] REG_SOURCE_FORMAT      = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_DESTINATION_FORMAT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_OPACITY            = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_SOURCE_SELECT      = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_FILL_COLOR         = 3'd4;

  localparam logic [1:0] SRC_BGR888   = 2'd0;
  localparam logic [1:0] SRC_BGRA8888 = 2'd1;
  localparam logic [1:0] SRC_RGB565   = 2'd2;

  localparam logic DST_BGR888 = 1'b0;
  localparam logic DST_RGB565 = 1'b1;

  localparam logic SEL_PIXEL = 1'b0;
  localparam logic SEL_FILL  = 1'b1;

  typedef struct packed {
    logic [1:0]  source_format;
    logic        destination_format;
    logic [7:0]  opacity;
    logic        source_select;
    logic [23:0] fill_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  fg_r;
    logic [7:0]  fg_g;
    logic [7:0]  fg_b;
    logic [7:0]  bg_r;
    logic [7:0]  bg_g;
    logic [7:0]  bg_b;
    logic [15:0] alpha_sum;
    logic        dst565;
    logic [23:0] dest_raw;
  } entry_t;

  // floor(x / 255) for x up to 65279
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [32:0] p;
    p = {17'd0, x} * 33'd32897;
    return p[30:23];
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [12:0] x;
    logic [26:0] p;
    x = {8'd0, v} * 13'd255 + 13'd15;
    p = {14'd0, x} * 27'd8457;
    return p[25:18];
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [13:0] x;
    logic [28:0] p;
    x = {8'd0, v} * 14'd255 + 14'd31;
    p = {15'd0, x} * 29'd16645;
    return p[27:20];
  endfunction

  function automatic logic [4:0] narrow5(input logic [7:0] v);
    logic [12:0] x;
    logic [7:0]  q;
    x = {5'd0, v} * 13'd31 + 13'd127;
    q = div255({3'd0, x});
    return q[4:0];
  endfunction

  function automatic logic [5:0] narrow6(input logic [7:0] v);
    logic [13:0] x;
    logic [7:0]  q;
    x = {6'd0, v} * 14'd63 + 14'd127;
    q = div255({2'd0, x});
    return q[5:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/abpc_front.sv =====
// Front stage: accept an item, unpack source and destination, form the alpha product.
`default_nettype none
module abpc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire abpc_pkg::cfg_t  cfg,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [31:0]     src_pixel,
  input  wire logic [23:0]     dest_pixel,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output abpc_pkg::entry_t     out_entry
);
  import abpc_pkg::*;

  entry_t     entry_next;
  logic [7:0] salpha;
  logic       dst565;

  assign in_ready = !out_valid || out_ready;
  assign dst565   = cfg.destination_format == DST_RGB565;

  always_comb begin
    entry_next = '0;
    salpha     = 8'd255;
    if (cfg.source_select == SEL_FILL) begin
      entry_next.fg_r = cfg.fill_color[23:16];
      entry_next.fg_g = cfg.fill_color[15:8];
      entry_next.fg_b = cfg.fill_color[7:0];
    end else if (cfg.source_format == SRC_RGB565) begin
      entry_next.fg_r = widen5(src_pixel[15:11]);
      entry_next.fg_g = widen6(src_pixel[10:5]);
      entry_next.fg_b = widen5(src_pixel[4:0]);
    end else begin
      entry_next.fg_r = src_pixel[23:16];
      entry_next.fg_g = src_pixel[15:8];
      entry_next.fg_b = src_pixel[7:0];
      if (cfg.source_format == SRC_BGRA8888) begin
        salpha = src_pixel[31:24];
      end
    end
    if (dst565) begin
      entry_next.bg_r = widen5(dest_pixel[15:11]);
      entry_next.bg_g = widen6(dest_pixel[10:5]);
      entry_next.bg_b = widen5(dest_pixel[4:0]);
    end else begin
      entry_next.bg_r = dest_pixel[23:16];
      entry_next.bg_g = dest_pixel[15:8];
      entry_next.bg_b = dest_pixel[7:0];
    end
    entry_next.alpha_sum = {8'd0, salpha} * {8'd0, cfg.opacity} + 16'd127;
    entry_next.dst565    = dst565;
    entry_next.dest_raw  = dest_pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_entry <= entry_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/abpc_fifo.sv =====
// Short queue of unpacked items between front and back.
`default_nettype none
module abpc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire abpc_pkg::entry_t  wr_data,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output abpc_pkg::entry_t       rd_data
);
  import abpc_pkg::*;

  localparam int PtrWidth = $clog2(QueueDepth);

  entry_t              mem [QueueDepth];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [PtrWidth:0]   count;
  logic                push;
  logic                pop;

  assign wr_ready = count != (PtrWidth+1)'(QueueDepth);
  assign rd_valid = count != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/abpc_back.sv =====
// Back pipeline: effective alpha, channel blend, divide and pack into the destination format.
`default_nettype none
module abpc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire abpc_pkg::entry_t  in_entry,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [23:0]            result_pixel,
  output logic                   write_enable
);
  import abpc_pkg::*;

  typedef struct packed {
    logic [7:0]  fg_r;
    logic [7:0]  fg_g;
    logic [7:0]  fg_b;
    logic [7:0]  bg_r;
    logic [7:0]  bg_g;
    logic [7:0]  bg_b;
    logic [7:0]  alpha;
    logic        dst565;
    logic [23:0] dest_raw;
  } alpha_st_t;

  typedef struct packed {
    logic [7:0]  fg_r;
    logic [7:0]  fg_g;
    logic [7:0]  fg_b;
    logic [15:0] sum_r;
    logic [15:0] sum_g;
    logic [15:0] sum_b;
    logic        opaque;
    logic        blank;
    logic        dst565;
    logic [23:0] dest_raw;
  } mix_st_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic        blank;
    logic        dst565;
    logic [23:0] dest_raw;
  } chan_st_t;

  logic      en;
  logic      v1, v2, v3;
  alpha_st_t s1;
  mix_st_t   s2;
  chan_st_t  s3;
  logic [7:0] inv_a;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign inv_a    = 8'd255 - s1.alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.fg_r     <= in_entry.fg_r;
      s1.fg_g     <= in_entry.fg_g;
      s1.fg_b     <= in_entry.fg_b;
      s1.bg_r     <= in_entry.bg_r;
      s1.bg_g     <= in_entry.bg_g;
      s1.bg_b     <= in_entry.bg_b;
      s1.alpha    <= div255(in_entry.alpha_sum);
      s1.dst565   <= in_entry.dst565;
      s1.dest_raw <= in_entry.dest_raw;

      s2.fg_r     <= s1.fg_r;
      s2.fg_g     <= s1.fg_g;
      s2.fg_b     <= s1.fg_b;
      s2.sum_r    <= {8'd0, s1.fg_r} * {8'd0, s1.alpha}
                   + {8'd0, s1.bg_r} * {8'd0, inv_a} + 16'd127;
      s2.sum_g    <= {8'd0, s1.fg_g} * {8'd0, s1.alpha}
                   + {8'd0, s1.bg_g} * {8'd0, inv_a} + 16'd127;
      s2.sum_b    <= {8'd0, s1.fg_b} * {8'd0, s1.alpha}
                   + {8'd0, s1.bg_b} * {8'd0, inv_a} + 16'd127;
      s2.opaque   <= s1.alpha == 8'd255;
      s2.blank    <= s1.alpha == 8'd0;
      s2.dst565   <= s1.dst565;
      s2.dest_raw <= s1.dest_raw;

      s3.r        <= s2.opaque ? s2.fg_r : div255(s2.sum_r);
      s3.g        <= s2.opaque ? s2.fg_g : div255(s2.sum_g);
      s3.b        <= s2.opaque ? s2.fg_b : div255(s2.sum_b);
      s3.blank    <= s2.blank;
      s3.dst565   <= s2.dst565;
      s3.dest_raw <= s2.dest_raw;

      write_enable <= !s3.blank;
      if (s3.blank) begin
        result_pixel <= s3.dest_raw;
      end else if (s3.dst565) begin
        result_pixel <= {8'd0, narrow5(s3.r), narrow6(s3.g), narrow5(s3.b)};
      end else begin
        result_pixel <= {s3.r, s3.g, s3.b};
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/alpha_blend_pixel_compositor.sv =====
// Top level of the source-over alpha blend compositor: configuration registers and stage wiring.
`default_nettype none
// Takes one source/destination pixel pair per clock while s_tready is high and returns one
// result per pair, in order. An item passes one front register, a four-entry queue and a
// four-stage back pipeline; the queue lets the input keep accepting while the output is held.
// Configuration registers take effect for items accepted after the write.
module alpha_blend_pixel_compositor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // src_pixel[31:0], dest_pixel[55:32]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // result_pixel[23:0]
  output logic             m_tuser,   // write_enable
  input  wire logic        cfg_we,
  input  wire logic [abpc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  wire logic [abpc_pkg::CfgDataWidth-1:0]  cfg_data
);
  import abpc_pkg::*;

  cfg_t   cfg;
  logic   f_valid;
  logic   f_ready;
  entry_t f_entry;
  logic   q_valid;
  logic   q_ready;
  entry_t q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format      <= SRC_BGR888;
      cfg.destination_format <= DST_BGR888;
      cfg.opacity            <= 8'd255;
      cfg.source_select      <= SEL_PIXEL;
      cfg.fill_color         <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_FORMAT:      cfg.source_format      <= cfg_data[1:0];
        REG_DESTINATION_FORMAT: cfg.destination_format <= cfg_data[0];
        REG_OPACITY:            cfg.opacity            <= cfg_data[7:0];
        REG_SOURCE_SELECT:      cfg.source_select      <= cfg_data[0];
        REG_FILL_COLOR:         cfg.fill_color         <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  abpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .src_pixel    (s_tdata[31:0]),
    .dest_pixel   (s_tdata[55:32]),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .out_entry    (f_entry)
  );

  abpc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_entry),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_entry)
  );

  abpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (q_valid),
    .in_ready     (q_ready),
    .in_entry     (q_entry),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .result_pixel (m_tdata),
    .write_enable (m_tuser)
  );

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking stream testbench for the alpha blend pixel compositor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import abpc_pkg::*;

  localparam logic [1:0] SRC_UNDEFINED = 2'd3;
  localparam logic [CfgIndexWidth-1:0] REG_UNUSED = 3'd7;
  localparam int QuietLimit = 1000;
  localparam int RandomItems = 700;

  typedef struct packed {
    logic [31:0] src;
    logic [23:0] dst;
  } pixel_pair_t;

  typedef struct packed {
    logic [23:0] pixel;
    logic        written;
  } blend_result_t;

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;  // src_pixel[31:0], dest_pixel[55:32]
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;       // result_pixel[23:0]
  logic m_tuser;              // write_enable
  logic cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  logic [1:0]  cur_src_fmt = SRC_BGR888;
  logic        cur_dst_fmt = DST_BGR888;
  logic [7:0]  cur_opacity = 8'd255;
  logic        cur_sel = SEL_PIXEL;
  logic [23:0] cur_fill = 24'h0;

  pixel_pair_t   pixel_pairs[$];
  blend_result_t due_pixels[$];

  int pairs_queued = 0;
  int pairs_taken = 0;
  int results_seen = 0;
  int unwritten_count = 0;
  int error_count = 0;
  int reg_writes = 0;
  int phases = 0;
  int src_wait = 0;
  int snk_wait = 0;
  int quiet_cycles = 0;
  bit src_idle = 1'b1;
  bit snk_idle = 1'b1;

  alpha_blend_pixel_compositor DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned expand5(input int unsigned v);
    return (v * 255 + 15) / 31;
  endfunction

  function automatic int unsigned expand6(input int unsigned v);
    return (v * 255 + 31) / 63;
  endfunction

  function automatic int unsigned compress5(input int unsigned v);
    return (v * 31 + 127) / 255;
  endfunction

  function automatic int unsigned compress6(input int unsigned v);
    return (v * 63 + 127) / 255;
  endfunction

  function automatic int unsigned blend_chan(input int unsigned fgv, input int unsigned bgv,
                                             input int unsigned a);
    return (fgv * a + bgv * (255 - a) + 127) / 255;
  endfunction

  function automatic blend_result_t blend_pixel(input logic [31:0] src, input logic [23:0] dst);
    int unsigned r, g, b, br, bg, bb, sa, a;
    logic [4:0] r5, b5;
    logic [5:0] g6;
    blend_result_t res;
    if (cur_sel == SEL_FILL) begin
      r = {24'd0, cur_fill[23:16]};
      g = {24'd0, cur_fill[15:8]};
      b = {24'd0, cur_fill[7:0]};
      sa = 255;
    end else if (cur_src_fmt == SRC_RGB565) begin
      r = expand5({27'd0, src[15:11]});
      g = expand6({26'd0, src[10:5]});
      b = expand5({27'd0, src[4:0]});
      sa = 255;
    end else begin
      r = {24'd0, src[23:16]};
      g = {24'd0, src[15:8]};
      b = {24'd0, src[7:0]};
      sa = (cur_src_fmt == SRC_BGRA8888) ? {24'd0, src[31:24]} : 32'd255;
    end
    a = (sa * {24'd0, cur_opacity} + 127) / 255;
    if (a == 0) begin
      res.pixel = dst;
      res.written = 1'b0;
      return res;
    end
    if (a != 255) begin
      if (cur_dst_fmt == DST_RGB565) begin
        br = expand5({27'd0, dst[15:11]});
        bg = expand6({26'd0, dst[10:5]});
        bb = expand5({27'd0, dst[4:0]});
      end else begin
        br = {24'd0, dst[23:16]};
        bg = {24'd0, dst[15:8]};
        bb = {24'd0, dst[7:0]};
      end
      r = blend_chan(r, br, a);
      g = blend_chan(g, bg, a);
      b = blend_chan(b, bb, a);
    end
    if (cur_dst_fmt == DST_RGB565) begin
      r5 = 5'(compress5(r));
      g6 = 6'(compress6(g));
      b5 = 5'(compress5(b));
      res.pixel = {8'd0, r5, g6, b5};
    end else begin
      res.pixel = {r[7:0], g[7:0], b[7:0]};
    end
    res.written = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    if (error_count < 100)
      $display("%0t: result %0d %s: expected %0h, got %0h", $time, results_seen, what,
               want_v, got_v);
    error_count++;
  endtask

  task automatic send(input logic [31:0] src, input logic [23:0] dst);
    pixel_pairs.push_back('{src, dst});
    pairs_queued++;
  endtask

  task automatic settle();
    while (pairs_taken != pairs_queued || due_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    phases++;
  endtask

  task automatic set_reg(input logic [CfgIndexWidth-1:0] idx,
                         input logic [CfgDataWidth-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SOURCE_FORMAT:      cur_src_fmt = data[1:0];
      REG_DESTINATION_FORMAT: cur_dst_fmt = data[0];
      REG_OPACITY:            cur_opacity = data[7:0];
      REG_SOURCE_SELECT:      cur_sel = data[0];
      REG_FILL_COLOR:         cur_fill = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic configure(input logic [1:0] sf, input logic df, input logic [7:0] op,
                           input logic sel, input logic [23:0] fill);
    logic [23:0] junk;
    junk = 24'($urandom);
    set_reg(REG_SOURCE_FORMAT, {junk[23:2], sf});
    set_reg(REG_DESTINATION_FORMAT, {junk[23:1], df});
    set_reg(REG_OPACITY, {junk[23:8], op});
    set_reg(REG_SOURCE_SELECT, {junk[23:1], sel});
    set_reg(REG_FILL_COLOR, fill);
  endtask

  always @(posedge clk) begin : driver
    pixel_pair_t next_pair;
    if (rst) begin
      s_tvalid <= 1'b0;
      src_wait <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (src_wait != 0) begin
        s_tvalid <= 1'b0;
        src_wait <= src_wait - 1;
      end else if (pixel_pairs.size() != 0) begin
        next_pair = pixel_pairs.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {next_pair.dst, next_pair.src};
        src_wait <= src_idle ? $urandom_range(0, 6) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    blend_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_pixels.size() == 0) begin
          report_mismatch("arrived with nothing due", 32'h0, {8'h0, m_tdata});
        end else begin
          want = due_pixels.pop_front();
          if (m_tdata !== want.pixel)
            report_mismatch("result_pixel", {8'h0, want.pixel}, {8'h0, m_tdata});
          if (m_tuser !== want.written)
            report_mismatch("write_enable", {31'h0, want.written}, {31'h0, m_tuser});
          if (!want.written) unwritten_count++;
        end
        results_seen++;
        snk_wait = snk_idle ? $urandom_range(0, 6) : 0;
      end
      if (s_tvalid && s_tready) begin
        due_pixels.push_back(blend_pixel(s_tdata[31:0], s_tdata[55:32]));
        pairs_taken++;
      end
      if (snk_wait != 0) begin
        m_tready <= 1'b0;
        snk_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
               QuietLimit, due_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int random_sent;
    logic [31:0] px;
    logic [1:0] sf;
    logic df, sel;
    logic [7:0] op;
    random_sent = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset values: opaque BGR888 over BGR888, byte 3 ignored
    send(32'h0000_0000, 24'hFF_FFFF);
    send(32'hFFFF_FFFF, 24'h00_0000);
    settle();

    configure(SRC_BGRA8888, DST_BGR888, 8'd255, SEL_PIXEL, 24'h0);
    send(32'h00FF_FFFF, 24'h12_3456);
    send(32'hFF00_0000, 24'hFF_FFFF);
    send(32'h01FF_FFFF, 24'h00_0000);
    send(32'h80FF_00FF, 24'h00_FF00);
    send(32'hFE12_3456, 24'hAB_CDEF);
    settle();

    configure(SRC_BGRA8888, DST_RGB565, 8'd200, SEL_PIXEL, 24'h0);
    send(32'hFFFF_FFFF, 24'hFF_0000);
    send(32'h8000_0000, 24'hA5_FFFF);
    send(32'h01AB_CDEF, 24'h5A_1234);
    settle();

    configure(SRC_RGB565, DST_RGB565, 8'd255, SEL_PIXEL, 24'h0);
    send(32'hFFFF_FFFF, 24'h00_0000);
    send(32'hFFFF_0000, 24'hFF_FFFF);
    send(32'h0000_F800, 24'h00_07E0);
    send(32'h0000_07E0, 24'h00_001F);
    send(32'h0000_001F, 24'h00_F800);
    settle();

    configure(SRC_RGB565, DST_BGR888, 8'd0, SEL_PIXEL, 24'h0);
    send(32'h1234_FFFF, 24'h65_4321);
    settle();

    set_reg(REG_OPACITY, 24'd1);
    set_reg(REG_UNUSED, 24'($urandom));
    send(32'h0000_FFFF, 24'h00_0000);
    settle();

    // fill ignores source format and source alpha
    configure(SRC_BGRA8888, DST_BGR888, 8'd128, SEL_FILL, 24'hFF_FFFF);
    send(32'h0000_0000, 24'h00_0000);
    send(32'h00AB_CDEF, 24'h13_579B);
    settle();

    configure(SRC_UNDEFINED, DST_BGR888, 8'd255, SEL_PIXEL, 24'h0);
    send(32'h0012_3456, 24'hFF_FFFF);
    send(32'h00FF_FFFF, 24'h00_0000);
    settle();

    while (random_sent < RandomItems) begin
      src_idle = $urandom_range(0, 3) != 0;
      snk_idle = $urandom_range(0, 3) != 0;
      sf = 2'($urandom_range(0, 3));
      df = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
        0: op = 8'd0;
        1: op = 8'd255;
        2: op = 8'd1;
        3: op = 8'd254;
        default: op = 8'($urandom);
      endcase
      sel = $urandom_range(0, 3) == 0 ? SEL_FILL : SEL_PIXEL;
      configure(sf, df, op, sel, 24'($urandom));
      n = $urandom_range(30, 70);
      for (int i = 0; i < n; i++) begin
        px = $urandom;
        case ($urandom_range(0, 3))
          0: px[31:24] = 8'h00;
          1: px[31:24] = 8'hFF;
          default: ;
        endcase
        send(px, 24'($urandom));
      end
      random_sent += n;
      settle();
    end

    repeat (10) @(posedge clk);
    $display("Blended %0d pixel pairs across %0d register settings (%0d register writes).",
             pairs_taken, phases, reg_writes);
    $display("Checked %0d results, %0d of them left the destination unwritten.",
             results_seen, unwritten_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== alpha_blend_pixel_compositor.f =====
src/abpc_pkg.sv
src/abpc_front.sv
src/abpc_fifo.sv
src/abpc_back.sv
src/alpha_blend_pixel_compositor.sv
sim/tb_top.sv
